/* hw/rtl/assert_macros.svh */
// Concurrent assertion helpers. They sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SSET_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sset: same-cycle check failed");

`define SSET_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sset: next-cycle check failed");

`endif

/* hw/rtl/sset_pkg.sv */
package sset_pkg;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TEST   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PREV   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic eq;
        logic below;
        logic closer;
    } cmp_flags_t;

endpackage

/* hw/rtl/sset_if.sv */
interface sset_req_if;
    import sset_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [POS_W-1:0]   position;

    modport source (output valid, output cmd, output key, output position, input ready);
    modport sink (input valid, input cmd, input key, input position, output ready);
endinterface

interface sset_rsp_if;
    import sset_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output found, output value, output count,
                    input ready);
    modport sink (input valid, input status, input found, input value, input count,
                  output ready);
endinterface

/* hw/rtl/sset_keystore.sv */
module sset_keystore #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/sset_cmp.sv */
module sset_cmp #(
    parameter int KW = 16
) (
    input  logic [KW-1:0]        stored,
    input  logic [KW-1:0]        probe,
    input  logic [KW-1:0]        best_dist,
    output sset_pkg::cmp_flags_t flags,
    output logic [KW-1:0]        gap
);
    import sset_pkg::*;

    logic above;

    assign above        = stored > probe;
    assign gap          = above ? (stored - probe) : (probe - stored);
    assign flags.eq     = stored == probe;
    assign flags.below  = stored < probe;
    assign flags.closer = gap < best_dist;

endmodule

/* hw/rtl/sorted_set_nearest_wrap_navigator_core.sv */
// S_IDLE takes a request; S_SCAN reads the stored keys in order for a hit, the nearest key and
// the count of smaller keys; S_DECIDE picks the next step. Insert shifts larger entries up in
// S_SHIFT, one entry per cycle, then writes the key in S_INS; remove shifts later entries down in
// S_REMOVE; a hitting next or prev and a read fetch a key in S_LOAD; S_DONE gives the result.
// One command at a time: req is ready only in S_IDLE, entered as the result appears; S_DONE waits
// while an older result waits. Reset clears state, entry count and rsp.valid, not key memory.
`include "assert_macros.svh"

module sorted_set_nearest_wrap_navigator_core #(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sset_req_if.sink    req,
    sset_rsp_if.source  rsp
);
    import sset_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_SHIFT  = 8'b0000_1000,
        S_INS    = 8'b0001_0000,
        S_REMOVE = 8'b0010_0000,
        S_LOAD   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic [AW-1:0]         at_reg, at_next;
    logic [CW-1:0]         lt_reg, lt_next;
    logic [KEY_BITS-1:0]   best_reg, best_next;
    logic [KEY_BITS-1:0]   bdist_reg, bdist_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [STATUS_W-1:0]   st_reg, st_next;
    logic [KEY_BITS-1:0]   val_reg, val_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_found_reg, out_found_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic [AW-1:0]         rd_addr;
    logic [KEY_BITS-1:0]   rd_data;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [KEY_BITS-1:0]   wdata;

    cmp_flags_t            flags;
    logic [KEY_BITS-1:0]   gap;
    logic                  scan_last;

    sset_keystore #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sset_cmp #(
        .KW (KEY_BITS)
    ) u_cmp (
        .stored    (rd_data),
        .probe     (key_reg),
        .best_dist (bdist_reg),
        .flags     (flags),
        .gap       (gap)
    );

    assign scan_last = (CW'(idx_reg) + CW'(1)) == cnt_reg;

    assign req.ready  = state_reg == S_IDLE;
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.found  = out_found_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.count  = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        at_next         = at_reg;
        lt_next         = lt_reg;
        best_next       = best_reg;
        bdist_next      = bdist_reg;
        ptr_next        = ptr_reg;
        st_next         = st_reg;
        val_next        = val_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        rd_addr         = '0;
        we              = 1'b0;
        waddr           = '0;
        wdata           = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next = req.cmd;
                    key_next = KEY_BITS'(req.key);
                    pos_next = req.position;
                    idx_next = '0;
                    hit_next = 1'b0;
                    at_next  = '0;
                    lt_next  = '0;
                    st_next  = ST_MISS;
                    val_next = '0;
                    rd_addr  = '0;
                    state_next = (cnt_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (flags.eq)
                begin
                    hit_next = 1'b1;
                    at_next  = idx_reg;
                end
                if (flags.below)
                begin
                    lt_next = lt_reg + CW'(1);
                end
                if (idx_reg == '0 || flags.closer)
                begin
                    best_next  = rd_data;
                    bdist_next = gap;
                end
                rd_addr  = idx_reg + AW'(1);
                idx_next = idx_reg + AW'(1);
                if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            st_next = ST_MISS;
                        end
                        else if (cnt_reg == CW'(CAPACITY))
                        begin
                            st_next = ST_FULL;
                        end
                        else if (cnt_reg > lt_reg)
                        begin
                            rd_addr    = AW'(cnt_reg - CW'(1));
                            ptr_next   = cnt_reg;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end

                    CMD_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            st_next = ST_MISS;
                        end
                        else if ((CW'(at_reg) + CW'(1)) < cnt_reg)
                        begin
                            rd_addr    = at_reg + AW'(1);
                            ptr_next   = CW'(at_reg);
                            state_next = S_REMOVE;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - CW'(1);
                            st_next  = ST_OK;
                        end
                    end

                    CMD_TEST:
                    begin
                        st_next = hit_reg ? ST_OK : ST_MISS;
                    end

                    CMD_NEXT, CMD_PREV:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (!hit_reg)
                        begin
                            val_next = best_reg;
                            st_next  = ST_OK;
                        end
                        else
                        begin
                            if (cmd_reg == CMD_NEXT)
                            begin
                                rd_addr = ((CW'(at_reg) + CW'(1)) < cnt_reg) ?
                                          (at_reg + AW'(1)) : '0;
                            end
                            else
                            begin
                                rd_addr = (at_reg != '0) ?
                                          (at_reg - AW'(1)) : AW'(cnt_reg - CW'(1));
                            end
                            state_next = S_LOAD;
                        end
                    end

                    CMD_READ:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (CPW'(pos_reg) < CPW'(cnt_reg))
                        begin
                            rd_addr    = AW'(pos_reg);
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            st_next = ST_MISS;
                        end
                    end

                    default:
                    begin
                        st_next = ST_MISS;
                    end
                endcase
            end

            S_SHIFT:
            begin
                we       = 1'b1;
                waddr    = AW'(ptr_reg);
                wdata    = rd_data;
                ptr_next = ptr_reg - CW'(1);
                rd_addr  = AW'(ptr_reg - CW'(2));
                if ((ptr_reg - CW'(1)) == lt_reg)
                begin
                    state_next = S_INS;
                end
            end

            S_INS:
            begin
                we         = 1'b1;
                waddr      = AW'(lt_reg);
                wdata      = key_reg;
                cnt_next   = cnt_reg + CW'(1);
                st_next    = ST_OK;
                state_next = S_DONE;
            end

            S_REMOVE:
            begin
                we       = 1'b1;
                waddr    = AW'(ptr_reg);
                wdata    = rd_data;
                ptr_next = ptr_reg + CW'(1);
                rd_addr  = AW'(ptr_reg + CW'(2));
                if ((ptr_reg + CW'(2)) >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
            end

            S_LOAD:
            begin
                val_next   = rd_data;
                st_next    = ST_OK;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_found_next  = hit_reg;
                    out_value_next  = VALUE_W'(val_reg);
                    out_count_next  = COUNT_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        at_reg         <= at_next;
        lt_reg         <= lt_next;
        best_reg       <= best_next;
        bdist_reg      <= bdist_next;
        ptr_reg        <= ptr_next;
        st_reg         <= st_next;
        val_reg        <= val_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    `SSET_ASSERT_NEXT(a_busy_after_transfer, req.valid && req.ready, !req.ready)
    `SSET_ASSERT_IMPL(a_count_in_range, 1'b1, cnt_reg <= CW'(CAPACITY))
    `SSET_ASSERT_IMPL(a_shift_window, state_reg == S_SHIFT, (ptr_reg > lt_reg) && (ptr_reg <= cnt_reg))
    `SSET_ASSERT_IMPL(a_value_only_on_ok, rsp.valid && (rsp.status != ST_OK), rsp.value == '0)
    `SSET_ASSERT_IMPL(a_empty_means_zero, rsp.valid && (rsp.status == ST_EMPTY), rsp.count == '0)

endmodule

/* bench/tb_sorted_set_nearest_wrap_navigator_core.sv */
`timescale 1ns / 100ps

module tb_sorted_set_nearest_wrap_navigator_core;
    import sset_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASE_LEN    = 100;
    localparam int KEY_POOL     = 48;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 250;
    localparam int TAIL_CYCLES  = 80;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

    localparam int MIX_FILL  = 0;
    localparam int MIX_EVEN  = 1;
    localparam int MIX_DRAIN = 2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
    } nav_result_t;

    class key_set_shadow;
        logic [KEY_W-1:0] stored [CAPACITY];
        int               filled;
        nav_result_t      replies_due [$];
        int               mismatches;

        function void log_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                  logic [POS_W-1:0] p);
            nav_result_t r;
            int          at;
            int          i;
            int          d;
            int          best_d;
            bit          hit;
            hit = 1'b0;
            at = 0;
            for (i = 0; i < filled; i++)
            begin
                if (!hit && stored[i] == k)
                begin
                    hit = 1'b1;
                    at = i;
                end
            end
            r.status = ST_MISS;
            r.found  = hit;
            r.value  = '0;
            case (c)
                CMD_INSERT:
                begin
                    if (!hit)
                    begin
                        if (filled >= CAPACITY)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            i = filled;
                            while (i > 0 && stored[i-1] > k)
                            begin
                                stored[i] = stored[i-1];
                                i--;
                            end
                            stored[i] = k;
                            filled++;
                            r.status = ST_OK;
                        end
                    end
                end
                CMD_REMOVE:
                begin
                    if (hit)
                    begin
                        for (i = at; i + 1 < filled; i++)
                        begin
                            stored[i] = stored[i+1];
                        end
                        filled--;
                        r.status = ST_OK;
                    end
                end
                CMD_TEST:
                begin
                    r.status = hit ? ST_OK : ST_MISS;
                end
                CMD_NEXT, CMD_PREV:
                begin
                    if (filled == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        r.status = ST_OK;
                        if (!hit)
                        begin
                            r.value = stored[0];
                            best_d = int'(stored[0]) - int'(k);
                            if (best_d < 0)
                                best_d = -best_d;
                            for (i = 1; i < filled; i++)
                            begin
                                d = int'(stored[i]) - int'(k);
                                if (d < 0)
                                    d = -d;
                                if (d < best_d)
                                begin
                                    best_d = d;
                                    r.value = stored[i];
                                end
                            end
                        end
                        else if (c == CMD_NEXT)
                        begin
                            r.value = stored[(at + 1 < filled) ? at + 1 : 0];
                        end
                        else
                        begin
                            r.value = stored[(at > 0) ? at - 1 : filled - 1];
                        end
                    end
                end
                CMD_READ:
                begin
                    if (filled == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else if (int'(p) < filled)
                    begin
                        r.value = stored[p];
                        r.status = ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
            r.count = COUNT_W'(filled);
            replies_due = {replies_due, r};
        endfunction

        function void check_reply(nav_result_t got);
            nav_result_t want;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d found %0d value %h count %0d",
                             got.status, got.found, got.value, got.count);
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.value !== want.value || got.count !== want.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected status %0d found %0d value %h count %0d",
                             want.status, want.found, want.value, want.count);
                    $display("          got status %0d found %0d value %h count %0d",
                             got.status, got.found, got.value, got.count);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;
    int   key_pool [KEY_POOL];

    key_set_shadow shadow = new();

    sset_req_if req_ch ();
    sset_rsp_if rsp_ch ();

    sorted_set_nearest_wrap_navigator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task automatic issue(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                         input logic [POS_W-1:0] p);
        while (!calm && $urandom_range(99) < 16)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.key      <= k;
        req_ch.position <= p;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        shadow.log_command(c, k, p);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int slot;
        r = $urandom_range(99);
        if (shadow.filled > 0 && r < 35)
            return shadow.stored[$urandom_range(shadow.filled - 1)];
        if (shadow.filled > 0 && r < 50)
        begin
            slot = $urandom_range(shadow.filled - 1);
            if ($urandom_range(1))
                return shadow.stored[slot] + KEY_W'($urandom_range(1, 3));
            return shadow.stored[slot] - KEY_W'($urandom_range(1, 3));
        end
        if (r < 85)
            return KEY_W'(key_pool[$urandom_range(KEY_POOL - 1)]);
        return KEY_W'($urandom);
    endfunction

    task automatic random_item(input int mix);
        int               ins_w;
        int               rem_w;
        int               r;
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        ins_w = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 12 : 30;
        rem_w = (mix == MIX_FILL) ? 8 : (mix == MIX_DRAIN) ? 55 : 20;
        r = $urandom_range(99);
        if (r < ins_w)
            c = CMD_INSERT;
        else if (r < ins_w + rem_w)
            c = CMD_REMOVE;
        else if (r >= 97)
            c = $urandom_range(1) ? CMD_RSVD_A : CMD_RSVD_B;
        else
        begin
            case ($urandom_range(3))
                0: c = CMD_TEST;
                1: c = CMD_NEXT;
                2: c = CMD_PREV;
                default: c = CMD_READ;
            endcase
        end
        if (c == CMD_READ && shadow.filled > 0 && $urandom_range(99) < 70)
            p = POS_W'($urandom_range(shadow.filled - 1));
        else
            p = POS_W'($urandom_range(31));
        issue(c, pick_key(), p);
    endtask

    initial
    begin
        int i;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= CMD_INSERT;
        req_ch.key      <= '0;
        req_ch.position <= '0;
        rst_n           <= 1'b0;
        calm            <= 1'b0;
        key_pool[0] = 0;
        key_pool[1] = 65535;
        key_pool[2] = 1;
        key_pool[3] = 65534;
        key_pool[4] = 32768;
        key_pool[5] = 32767;
        for (i = 6; i < KEY_POOL; i++)
            key_pool[i] = $urandom_range(65535);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_NEXT, 16'h1234, 5'd0);
        issue(CMD_PREV, 16'h0000, 5'd0);
        issue(CMD_READ, 16'h0000, 5'd0);
        issue(CMD_REMOVE, 16'h0005, 5'd0);
        issue(CMD_TEST, 16'h0005, 5'd0);
        issue(CMD_INSERT, 16'hFFFF, 5'd0);
        issue(CMD_NEXT, 16'hFFFF, 5'd0);
        issue(CMD_INSERT, 16'h0000, 5'd0);
        issue(CMD_INSERT, 16'h8000, 5'd0);
        issue(CMD_INSERT, 16'h8000, 5'd0);
        issue(CMD_NEXT, 16'hFFFF, 5'd0);
        issue(CMD_PREV, 16'h0000, 5'd0);
        issue(CMD_NEXT, 16'h4000, 5'd0);
        issue(CMD_PREV, 16'hC000, 5'd0);
        issue(CMD_READ, 16'h0000, 5'd0);
        issue(CMD_READ, 16'h0000, 5'd2);
        issue(CMD_READ, 16'h0000, 5'd3);
        issue(CMD_READ, 16'hFFFF, 5'd31);
        issue(CMD_TEST, 16'h8000, 5'd0);
        issue(CMD_REMOVE, 16'h8000, 5'd0);
        issue(CMD_REMOVE, 16'h8000, 5'd0);
        issue(CMD_RSVD_A, 16'hFFFF, 5'd31);
        issue(CMD_RSVD_B, 16'h0000, 5'd0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm <= (i / PHASE_LEN == 6);
            case ((i / PHASE_LEN) % 4)
                0: random_item(MIX_FILL);
                2: random_item(MIX_DRAIN);
                default: random_item(MIX_EVEN);
            endcase
        end
        req_ch.valid <= 1'b0;
        calm <= 1'b0;

        while (shadow.replies_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        int          seen;
        int          hold;
        nav_result_t got;
        seen = 0;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status = rsp_ch.status;
                got.found  = rsp_ch.found;
                got.value  = rsp_ch.value;
                got.count  = rsp_ch.count;
                shadow.check_reply(got);
                seen++;
                if (seen == 150)
                    hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
